// File: sv/wildcard_glob_matcher_core_defines.svh
// Assertion macros used by the back end of the wildcard glob matcher RTL.
`ifndef WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WGM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wgm assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WGM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wgm assertion failed");

`else

`define WGM_ASSERT_IMP(lbl, ante, cons)
`define WGM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: sv/wgm_pkg.sv
// Shared constants, types and the star-closure function of the glob matcher.
package wgm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int POS_W       = PATTERN_MAX + 1;
	localparam int POS_IDX_W   = $clog2(POS_W);
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int WORD_W      = 64;
	localparam int CFG_IDX_W   = 3;

	localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
	localparam logic [BYTE_W-1:0] QUERY_BYTE = 8'h3F;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WORD0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

	// Item kinds after classification
	localparam logic [1:0] KIND_CONT  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// Decoded pattern, all masks limited to the used length
	typedef struct packed {
		logic [PATTERN_MAX*BYTE_W-1:0] pat;
		logic [PATTERN_MAX-1:0]        star_mask;
		logic [PATTERN_MAX-1:0]        query_mask;
		logic [PATTERN_MAX-1:0]        live_mask;
		logic [POS_IDX_W-1:0]          len;
		logic [POS_W-1:0]              init_set;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [1:0]             kind;
		logic [PATTERN_MAX-1:0] hit;
	} q_item_t;

	// Close a position set over runs of stars: a reachable star position
	// also reaches the next one. Parallel prefix, log2 levels.
	function automatic logic [POS_W-1:0] star_closure(
		input logic [POS_W-1:0]       set,
		input logic [PATTERN_MAX-1:0] star
	);
		logic [POS_W-1:0] g;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] gn;
		logic [POS_W-1:0] pn;
		g = set;
		p = {star, 1'b0};
		for (int d = 1; d < POS_W; d = d * 2) begin
			gn = g;
			pn = p;
			for (int j = d; j < POS_W; j++) begin
				gn[j] = g[j] | (p[j] & g[j-d]);
				pn[j] = p[j] & p[j-d];
			end
			g = gn;
			p = pn;
		end
		return g;
	endfunction

endpackage

// File: sv/wgm_cfg.sv
// Pattern registers and decode of the pattern into position masks.
module wgm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wgm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wgm_pkg::WORD_W-1:0]       cfg_data,
	output wgm_pkg::cfg_t                    cfg
);

	logic [wgm_pkg::WORD_W-1:0] word0_q;
	logic [wgm_pkg::WORD_W-1:0] word1_q;
	logic [wgm_pkg::WORD_W-1:0] word2_q;
	logic [wgm_pkg::WORD_W-1:0] word3_q;
	logic [wgm_pkg::LEN_W-1:0]  length_q;

	logic [4*wgm_pkg::WORD_W-1:0]                         all_words;
	logic [wgm_pkg::PATTERN_MAX*wgm_pkg::BYTE_W-1:0]      pat;
	logic [wgm_pkg::POS_IDX_W-1:0]                        len;
	logic [wgm_pkg::PATTERN_MAX-1:0]                      star_mask;
	logic [wgm_pkg::PATTERN_MAX-1:0]                      query_mask;
	logic [wgm_pkg::PATTERN_MAX-1:0]                      live_mask;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word0_q  <= '0;
			word1_q  <= '0;
			word2_q  <= '0;
			word3_q  <= '0;
			length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wgm_pkg::REG_WORD0:  word0_q  <= cfg_data;
				wgm_pkg::REG_WORD1:  word1_q  <= cfg_data;
				wgm_pkg::REG_WORD2:  word2_q  <= cfg_data;
				wgm_pkg::REG_WORD3:  word3_q  <= cfg_data;
				wgm_pkg::REG_LENGTH: length_q <= cfg_data[wgm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign all_words = {word3_q, word2_q, word1_q, word0_q};
	assign pat       = all_words[wgm_pkg::PATTERN_MAX*wgm_pkg::BYTE_W-1:0];

	// Clamp length to the pattern capacity
	always_comb begin
		if (length_q > wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX))
			len = wgm_pkg::POS_IDX_W'(wgm_pkg::PATTERN_MAX);
		else
			len = length_q[wgm_pkg::POS_IDX_W-1:0];
	end

	// Per-position class of the pattern byte, only inside the used length
	always_comb begin
		for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
			logic in_len;
			logic is_star;
			in_len        = wgm_pkg::POS_IDX_W'(i) < len;
			is_star       = pat[i*wgm_pkg::BYTE_W +: wgm_pkg::BYTE_W] == wgm_pkg::STAR_BYTE;
			star_mask[i]  = in_len & is_star;
			live_mask[i]  = in_len & ~is_star;
			query_mask[i] = in_len &
				(pat[i*wgm_pkg::BYTE_W +: wgm_pkg::BYTE_W] == wgm_pkg::QUERY_BYTE);
		end
	end

	assign cfg.pat        = pat;
	assign cfg.star_mask  = star_mask;
	assign cfg.query_mask = query_mask;
	assign cfg.live_mask  = live_mask;
	assign cfg.len        = len;
	assign cfg.init_set   = wgm_pkg::star_closure(wgm_pkg::POS_W'(1), star_mask);

endmodule

// File: sv/wgm_front.sv
// Front end: accepts text bytes and classifies them against the pattern.
module wgm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wgm_pkg::cfg_t                 cfg,
	input  logic                          push,
	input  logic [wgm_pkg::BYTE_W-1:0]    text_byte,
	input  logic                          starts_text,
	input  logic                          empty_text,
	output logic                          full,
	output logic                          q_push,
	output wgm_pkg::q_item_t              q_item,
	input  logic                          q_full
);

	logic              valid_s1;
	wgm_pkg::q_item_t  item_s1;
	wgm_pkg::q_item_t  item_c;
	logic              take;
	logic              drain;

	// Positions that advance on this byte: a '?' or an equal literal
	always_comb begin
		for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
			item_c.hit[i] = cfg.live_mask[i] & (cfg.query_mask[i] |
				(cfg.pat[i*wgm_pkg::BYTE_W +: wgm_pkg::BYTE_W] == text_byte));
		end
		if (empty_text)
			item_c.kind = wgm_pkg::KIND_EMPTY;
		else if (starts_text)
			item_c.kind = wgm_pkg::KIND_START;
		else
			item_c.kind = wgm_pkg::KIND_CONT;
	end

	assign drain  = valid_s1 & ~q_full;
	assign full   = valid_s1 & q_full;
	assign take   = push & ~full;
	assign q_push = drain;
	assign q_item = item_s1;

	// Stage 1 holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (drain)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item_c;
	end

endmodule

// File: sv/wgm_queue.sv
// Four-entry queue of classified items between front and back.
module wgm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wgm_pkg::q_item_t  din,
	output logic              full,
	input  logic              pop,
	output wgm_pkg::q_item_t  dout,
	output logic              empty
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	wgm_pkg::q_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == (PTR_W+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push & ~do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop & ~do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

// File: sv/wgm_back.sv
// Back end: advances the reachable position set and queues the results.
`include "wildcard_glob_matcher_core_defines.svh"

module wgm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wgm_pkg::cfg_t     cfg,
	input  logic              q_empty,
	input  wgm_pkg::q_item_t  q_item,
	output logic              q_pop,
	output logic              matched,
	output logic              empty,
	input  logic              pop
);

	logic [wgm_pkg::POS_W-1:0]       state_q;
	logic [wgm_pkg::POS_W-1:0]       base;
	logic [wgm_pkg::POS_W-1:0]       adv;
	logic [wgm_pkg::POS_W-1:0]       set_c;
	logic [wgm_pkg::PATTERN_MAX-1:0] live;
	logic                            take;

	logic       out_mem_q [2];
	logic       out_wr_q;
	logic       out_rd_q;
	logic [1:0] out_cnt_q;
	logic       out_pop;

	assign take  = ~q_empty & (out_cnt_q != 2'd2);
	assign q_pop = take;

	// One step of the position set: stars hold, hits move one forward
	always_comb begin
		base = (q_item.kind == wgm_pkg::KIND_CONT) ? state_q : cfg.init_set;
		live = base[wgm_pkg::PATTERN_MAX-1:0];
		adv  = {1'b0, cfg.star_mask & live} | {q_item.hit & live, 1'b0};
		if (q_item.kind == wgm_pkg::KIND_EMPTY)
			set_c = cfg.init_set;
		else
			set_c = wgm_pkg::star_closure(adv, cfg.star_mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (take)
			state_q <= set_c;
	end

	// Two-entry result buffer
	assign empty   = out_cnt_q == 2'd0;
	assign out_pop = pop & ~empty;
	assign matched = out_mem_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (take)
				out_wr_q <= ~out_wr_q;
			if (out_pop)
				out_rd_q <= ~out_rd_q;
			if (take & ~out_pop)
				out_cnt_q <= out_cnt_q + 2'd1;
			else if (out_pop & ~take)
				out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			out_mem_q[out_wr_q] <= set_c[cfg.len];
	end

	// Checks
	`WGM_ASSERT_NXT(a_take_gives_result, take, out_cnt_q != 2'd0)
	`WGM_ASSERT_NXT(a_empty_text_start, take && q_item.kind == wgm_pkg::KIND_EMPTY, state_q[0])
	`WGM_ASSERT_NXT(a_state_holds, !take, $stable(state_q))

endmodule

// File: sv/wildcard_glob_matcher_core.sv
// Top level of the streaming wildcard glob matcher.
//
// Matches a byte stream against a pattern of up to 32 bytes, where '?' takes
// any one byte and '*' any run of bytes. One result (matched) per text byte.
// Configuration: cfg_we/cfg_index/cfg_data write pattern words 0..3 and the
// pattern length (index 4); write only while no item is in flight.
// Input: push/full queue interface carrying text_byte, starts_text and
// empty_text; a transfer happens when push is high and full is low.
// Output: empty/pop queue interface; matched is valid while empty is low and
// a transfer happens when pop is high and empty is low.
// Throughput: one byte per cycle while the receiver keeps the result buffer
// drained; the back end updates the 33-bit reachable position set per item.
// Path: an input is held in the front register, then in the item queue, then
// in the result buffer, from which it is popped.
// Reset clears the pattern, the length and the position set; no clearing
// pass. When the receiver stalls, the result buffer, the four-entry item
// queue and the front register fill, and then full rises.
module wildcard_glob_matcher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wgm_pkg::WORD_W-1:0]     cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [wgm_pkg::BYTE_W-1:0]     text_byte,
	input  logic                           starts_text,
	input  logic                           empty_text,
	output logic                           empty,
	input  logic                           pop,
	output logic                           matched
);

	wgm_pkg::cfg_t    cfg;
	wgm_pkg::q_item_t f_item;
	wgm_pkg::q_item_t b_item;
	logic             f_push;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;

	wgm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wgm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.push        (push),
		.text_byte   (text_byte),
		.starts_text (starts_text),
		.empty_text  (empty_text),
		.full        (full),
		.q_push      (f_push),
		.q_item      (f_item),
		.q_full      (q_full)
	);

	wgm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_item),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (b_item),
		.empty  (q_empty)
	);

	wgm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_item  (b_item),
		.q_pop   (q_pop),
		.matched (matched),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the streaming wildcard glob matcher core.
`timescale 1ns / 1ps

module tb_top;

	localparam int ITEMS        = 1750;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 100;

	// Tracks the reachable pattern positions and queues expected match flags
	class glob_match_scoreboard;
		logic [wgm_pkg::WORD_W-1:0] pattern_words [4];
		logic [wgm_pkg::LEN_W-1:0]  pattern_len;
		logic [wgm_pkg::POS_W-1:0]  positions;
		bit                         expected_matched [$];
		int                         errors;

		function new();
			foreach (pattern_words[i]) pattern_words[i] = '0;
			pattern_len = '0;
			positions   = '0;
			errors      = 0;
		endfunction

		function void write_register(logic [wgm_pkg::CFG_IDX_W-1:0] idx,
				logic [wgm_pkg::WORD_W-1:0] data);
			case (idx)
				wgm_pkg::REG_WORD0:  pattern_words[0] = data;
				wgm_pkg::REG_WORD1:  pattern_words[1] = data;
				wgm_pkg::REG_WORD2:  pattern_words[2] = data;
				wgm_pkg::REG_WORD3:  pattern_words[3] = data;
				wgm_pkg::REG_LENGTH: pattern_len = data[wgm_pkg::LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// lengths above the maximum saturate
		function int used_len();
			return (pattern_len > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX
				: int'(pattern_len);
		endfunction

		function logic [wgm_pkg::BYTE_W-1:0] pattern_byte(int k);
			return pattern_words[k / 8][(k % 8) * 8 +: 8];
		endfunction

		// a reachable star also reaches the position after it; ascending order chains runs
		function logic [wgm_pkg::POS_W-1:0] close_stars(logic [wgm_pkg::POS_W-1:0] set,
				int len);
			for (int i = 0; i < len; i++)
				if (set[i] && pattern_byte(i) == wgm_pkg::STAR_BYTE)
					set[i+1] = 1'b1;
			return set;
		endfunction

		function logic [wgm_pkg::POS_W-1:0] step_positions(logic [wgm_pkg::POS_W-1:0] set,
				logic [wgm_pkg::BYTE_W-1:0] b, int len);
			logic [wgm_pkg::POS_W-1:0] nxt;
			logic [wgm_pkg::BYTE_W-1:0] pc;
			nxt = '0;
			for (int i = 0; i < len; i++) begin
				if (set[i]) begin
					pc = pattern_byte(i);
					if (pc == wgm_pkg::STAR_BYTE)
						nxt[i] = 1'b1;
					else if (pc == wgm_pkg::QUERY_BYTE || pc == b)
						nxt[i+1] = 1'b1;
				end
			end
			return close_stars(nxt, len);
		endfunction

		function void note_input(logic [wgm_pkg::BYTE_W-1:0] b, logic st, logic em);
			int len;
			logic [wgm_pkg::POS_W-1:0] origin;
			logic [wgm_pkg::POS_W-1:0] set;
			len = used_len();
			origin = '0;
			origin[0] = 1'b1;
			if (em) begin
				set = close_stars(origin, len);
			end else begin
				set = st ? close_stars(origin, len) : positions;
				set = step_positions(set, b, len);
			end
			positions = set;
			expected_matched.push_back(set[len]);
		endfunction

		function void check_result(logic m);
			bit exp_m;
			if (expected_matched.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual matched=%0b", $time, m);
				errors++;
			end else begin
				exp_m = expected_matched.pop_front();
				if (m !== exp_m) begin
					$display("%0t: matched mismatch, expected %0b, actual %0b", $time, exp_m, m);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_matched.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [wgm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wgm_pkg::WORD_W-1:0]    cfg_data;
	logic                          push;
	logic                          full;
	logic [wgm_pkg::BYTE_W-1:0]    text_byte;
	logic                          starts_text;
	logic                          empty_text;
	logic                          empty;
	logic                          pop;
	logic                          matched;

	glob_match_scoreboard          sb;
	logic [wgm_pkg::BYTE_W-1:0]    pat_bytes [wgm_pkg::PATTERN_MAX];
	int                            items_sent;
	int                            popped;
	bit                            sender_no_gaps;

	wildcard_glob_matcher_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.text_byte   (text_byte),
		.starts_text (starts_text),
		.empty_text  (empty_text),
		.empty       (empty),
		.pop         (pop),
		.matched     (matched)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mostly short idle gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// small alphabet so texts and patterns line up often
	function automatic logic [wgm_pkg::BYTE_W-1:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return 8'h61 + wgm_pkg::BYTE_W'($urandom_range(0, 2));
		if (r < 85) return 8'h00;
		return wgm_pkg::BYTE_W'($urandom);
	endfunction

	function automatic logic [wgm_pkg::BYTE_W-1:0] pick_pattern_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return wgm_pkg::STAR_BYTE;
		if (r < 35) return wgm_pkg::QUERY_BYTE;
		if (r < 80) return 8'h61 + wgm_pkg::BYTE_W'($urandom_range(0, 2));
		if (r < 90) return 8'h00;
		return wgm_pkg::BYTE_W'($urandom);
	endfunction

	function automatic logic [wgm_pkg::WORD_W-1:0] pack_word(int i);
		logic [wgm_pkg::WORD_W-1:0] w;
		for (int k = 0; k < 8; k++)
			w[k * 8 +: 8] = pat_bytes[i * 8 + k];
		return w;
	endfunction

	// one input transfer, then an optional gap
	task automatic send_item(input logic [wgm_pkg::BYTE_W-1:0] b, input logic st,
			input logic em);
		int gap;
		push        <= 1'b1;
		text_byte   <= b;
		starts_text <= st;
		empty_text  <= em;
		do @(posedge clk); while (full);
		sb.note_input(b, st, em);
		items_sent++;
		gap = sender_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every result is back
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// cfg_we stays high across back-to-back writes
	task automatic cfg_write(input logic [wgm_pkg::CFG_IDX_W-1:0] idx,
			input logic [wgm_pkg::WORD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_register(idx, data);
	endtask

	task automatic write_pattern(input logic [wgm_pkg::WORD_W-1:0] len_data,
			input bit touch_unused);
		cfg_write(wgm_pkg::REG_WORD0, pack_word(0));
		cfg_write(wgm_pkg::REG_WORD1, pack_word(1));
		cfg_write(wgm_pkg::REG_WORD2, pack_word(2));
		cfg_write(wgm_pkg::REG_WORD3, pack_word(3));
		cfg_write(wgm_pkg::REG_LENGTH, len_data);
		// indexes past the register map must have no effect
		if (touch_unused)
			cfg_write(wgm_pkg::REG_LENGTH + wgm_pkg::CFG_IDX_W'($urandom_range(1, 3)),
				{$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic fill_pattern_random();
		for (int k = 0; k < wgm_pkg::PATTERN_MAX; k++)
			pat_bytes[k] = wgm_pkg::BYTE_W'($urandom);
	endtask

	// new pattern, then a mix of matching texts, empty texts and noise
	task automatic random_phase();
		int r;
		int n_len;
		int used;
		int phase_items;
		int first_item;
		bit wide;
		logic [wgm_pkg::WORD_W-1:0] len_data;
		logic [wgm_pkg::BYTE_W-1:0] text_q [$];
		sender_no_gaps = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 99);
		if (r < 70)      n_len = $urandom_range(0, 10);
		else if (r < 85) n_len = $urandom_range(11, 31);
		else if (r < 93) n_len = wgm_pkg::PATTERN_MAX;
		else             n_len = $urandom_range(33, 63);
		wide = ($urandom_range(0, 9) == 0);
		for (int k = 0; k < wgm_pkg::PATTERN_MAX; k++)
			pat_bytes[k] = wide ? wgm_pkg::BYTE_W'($urandom) : pick_pattern_byte();
		len_data = '0;
		if ($urandom_range(0, 4) == 0)
			len_data = {$urandom, $urandom};
		len_data[wgm_pkg::LEN_W-1:0] = wgm_pkg::LEN_W'(n_len);
		write_pattern(len_data, $urandom_range(0, 3) == 0);
		used = (n_len > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX : n_len;
		phase_items = $urandom_range(40, 120);
		first_item = items_sent;
		while (items_sent - first_item < phase_items) begin
			r = $urandom_range(0, 99);
			text_q.delete();
			if (r < 70) begin
				// text built to fit the pattern, sometimes damaged or extended
				for (int k = 0; k < used; k++) begin
					if (pat_bytes[k] == wgm_pkg::STAR_BYTE)
						repeat ($urandom_range(0, 3)) text_q.push_back(pick_text_byte());
					else if (pat_bytes[k] == wgm_pkg::QUERY_BYTE)
						text_q.push_back(wgm_pkg::BYTE_W'($urandom));
					else
						text_q.push_back(pat_bytes[k]);
				end
				if ($urandom_range(0, 3) == 0 && text_q.size() > 0)
					text_q[$urandom_range(0, text_q.size() - 1)] = pick_text_byte();
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3)) text_q.push_back(pick_text_byte());
			end else if (r < 80) begin
				send_item(wgm_pkg::BYTE_W'($urandom), 1'($urandom), 1'b1);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8))
					send_item(wgm_pkg::BYTE_W'($urandom), $urandom_range(0, 3) == 0,
						$urandom_range(0, 9) == 0);
			end else begin
				repeat ($urandom_range(1, 15)) text_q.push_back(pick_text_byte());
			end
			if (r < 70 && text_q.size() == 0)
				send_item(wgm_pkg::BYTE_W'($urandom), 1'($urandom), 1'b1);
			foreach (text_q[i])
				send_item(text_q[i], i == 0, 1'b0);
		end
		settle();
	endtask

	// stimulus
	initial begin
		sb = new();
		items_sent     = 0;
		sender_no_gaps = 1'b0;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= wgm_pkg::REG_WORD0;
		cfg_data    <= '0;
		push        <= 1'b0;
		text_byte   <= '0;
		starts_text <= 1'b0;
		empty_text  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: byte with no text begun, empty text, continue after it
		send_item(8'h41, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		settle();

		// "*a?<nul>*": zero byte as a plain literal, trailing star
		fill_pattern_random();
		pat_bytes[0] = wgm_pkg::STAR_BYTE;
		pat_bytes[1] = "a";
		pat_bytes[2] = wgm_pkg::QUERY_BYTE;
		pat_bytes[3] = 8'h00;
		pat_bytes[4] = wgm_pkg::STAR_BYTE;
		write_pattern(64'd5, 1'b0);
		send_item("x", 1'b1, 1'b0);
		send_item("a", 1'b0, 1'b0);
		send_item("q", 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item("z", 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		settle();

		// all stars, length above the maximum saturates
		for (int k = 0; k < wgm_pkg::PATTERN_MAX; k++)
			pat_bytes[k] = wgm_pkg::STAR_BYTE;
		write_pattern(64'd63, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		settle();

		// single literal 0xFF
		fill_pattern_random();
		pat_bytes[0] = 8'hFF;
		write_pattern(64'd1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFE, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		settle();

		// pattern swapped in the middle of a text keeps the positions
		pat_bytes[0] = "a";
		pat_bytes[1] = "b";
		write_pattern(64'd2, 1'b0);
		send_item("a", 1'b1, 1'b0);
		settle();
		pat_bytes[0] = wgm_pkg::QUERY_BYTE;
		write_pattern(64'd2, 1'b0);
		send_item("b", 1'b0, 1'b0);
		settle();

		while (items_sent < ITEMS)
			random_phase();

		settle();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: random pops, bursts, and one long hold to back up the input
	initial begin
		int stall_left;
		int burst_left;
		bit hold_done;
		stall_left = 0;
		burst_left = 0;
		hold_done  = 1'b0;
		popped     = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(matched);
				popped++;
			end
			if (!hold_done && popped >= HOLD_AFTER && push) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
				burst_left = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				pop <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				burst_left = $urandom_range(50, 150);
				pop <= 1'b1;
			end else begin
				stall_left = pick_gap();
				pop <= (stall_left == 0);
			end
		end
	end

	// watchdog: too long without any transfer
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
